[rtl/core/assert_macros.svh]
// Assertion helper macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/core/rose_pkg.sv]
// ----------------------------------------------------------------------------
// Rose curve package
// Shared types, constants and register indexes for the rose vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none
package rose_pkg;
   localparam int MaxDivisionsDefault = 16384;
   localparam int PhaseBitsDefault    = 16;
   localparam int DivW   = 14;
   localparam int SizeW  = 12;
   localparam int CoordW = 13;

   // Register indexes.
   localparam logic [2:0] CSR_DIVISIONS   = 3'd0;
   localparam logic [2:0] CSR_PETAL_MULT  = 3'd1;
   localparam logic [2:0] CSR_ANGLE_STEP  = 3'd2;
   localparam logic [2:0] CSR_HALF_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_HALF_HEIGHT = 3'd4;

   // Polynomial constants in Q30.
   localparam logic signed [31:0] POLY_C1 = 32'sd1686629713;
   localparam logic signed [31:0] POLY_C3 = 32'sd693598668;
   localparam logic signed [31:0] POLY_C5 = 32'sd85569306;
   localparam logic signed [31:0] POLY_C7 = 32'sd5026995;
   localparam logic signed [31:0] POLY_C9 = 32'sd172272;

   // Datapath operations driven by the controller.
   typedef enum logic [3:0] {
      OP_NOP, OP_START, OP_GCD, OP_CNTDIV, OP_PREP, OP_MOD, OP_PHDIV,
      OP_SIN, OP_MUL, OP_FINISH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] sel;   // which phase or sine is being worked on
      logic       first; // first cycle of an iterative operation
   } cmd_type;

   typedef struct packed {
      logic busy;      // iterative unit still running
      logic need_init; // a new curve must begin
   } sts_type;
endpackage
`default_nettype wire

[rtl/core/rose_ctrl.sv]
// ----------------------------------------------------------------------------
// Rose controller
// Sequences the datapath through curve setup and per-word vertex work.
// ----------------------------------------------------------------------------
`default_nettype none
module rose_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_restart,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  csr_ready,
   output rose_pkg::cmd_type     cmd,
   input  wire rose_pkg::sts_type sts
);
   import rose_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_START  = 11'b00000000010,
      S_GCD    = 11'b00000000100,
      S_CNTDIV = 11'b00000001000,
      S_PREP   = 11'b00000010000,
      S_MOD    = 11'b00000100000,
      S_PHDIV  = 11'b00001000000,
      S_SIN    = 11'b00010000000,
      S_MUL    = 11'b00100000000,
      S_FINISH = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic       first_ff, first_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign csr_ready = (state_ff == S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      first_in = 1'b0;
      cmd.op   = OP_NOP;
      cmd.sel  = sel_ff;
      cmd.first = first_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart || sts.need_init) begin
                  state_in = S_START;
               end else begin
                  state_in = S_PREP; first_in = 1'b1;
               end
            end
         end
         S_START: begin
            cmd.op = OP_START; state_in = S_GCD; first_in = 1'b1;
         end
         S_GCD: begin
            cmd.op = OP_GCD;
            if (!first_ff && !sts.busy) begin
               state_in = S_CNTDIV; first_in = 1'b1;
            end
         end
         S_CNTDIV: begin
            cmd.op = OP_CNTDIV;
            if (!first_ff && !sts.busy) begin
               state_in = S_PREP; first_in = 1'b1;
            end
         end
         S_PREP: begin
            cmd.op = OP_PREP;
            if (!first_ff && !sts.busy) begin
               state_in = S_MOD; first_in = 1'b1; sel_in = 2'd0;
            end
         end
         S_MOD: begin
            cmd.op = OP_MOD;
            if (!first_ff && !sts.busy) begin
               state_in = S_PHDIV; first_in = 1'b1;
            end
         end
         S_PHDIV: begin
            cmd.op = OP_PHDIV;
            if (!first_ff && !sts.busy) begin
               first_in = 1'b1;
               if (sel_ff == 2'd1) begin
                  state_in = S_SIN; sel_in = 2'd0;
               end else begin
                  sel_in = 2'd1;
               end
            end
         end
         S_SIN: begin
            cmd.op = OP_SIN;
            if (!first_ff && !sts.busy) begin
               first_in = 1'b1;
               if (sel_ff == 2'd2) begin
                  state_in = S_MUL; sel_in = 2'd0;
               end else begin
                  sel_in = sel_ff + 2'd1;
               end
            end
         end
         S_MUL: begin
            cmd.op = OP_MUL;
            if (!first_ff && !sts.busy) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op = OP_FINISH; state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 2'd0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         first_ff <= first_in;
      end
   end
endmodule
`default_nettype wire

[rtl/core/rose_dp.sv]
// ----------------------------------------------------------------------------
// Rose datapath
// Config registers, curve state, a shared restoring divider, a shared
// polynomial step unit and a stepped multiplier for the coordinates.
// ----------------------------------------------------------------------------
`default_nettype none
module rose_dp #(
   parameter int MAX_DIVISIONS = rose_pkg::MaxDivisionsDefault,
   parameter int PHASE_BITS    = rose_pkg::PhaseBitsDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   input  wire logic                        csr_ready,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [rose_pkg::DivW-1:0]   csr_data,
   input  wire rose_pkg::cmd_type           cmd,
   output rose_pkg::sts_type                sts,
   output logic [rose_pkg::CoordW-1:0]      rsp_x,
   output logic [rose_pkg::CoordW-1:0]      rsp_y,
   output logic [rose_pkg::DivW-1:0]        rsp_vertex_total,
   output logic                             rsp_last
);
   import rose_pkg::*;

   localparam int DMax = MAX_DIVISIONS - 1;
   localparam int NumW = DivW + PHASE_BITS;   // dividend width of phase divide
   localparam int ProdW = 2 * DivW;           // t*k
   localparam int DivCntW = $clog2(ProdW + 1);

   // Configuration registers.
   logic [DivW-1:0]  div_ff, mul_ff, step_ff;
   logic [SizeW-1:0] hw_ff, hh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= DivW'(6); mul_ff <= DivW'(1); step_ff <= DivW'(1);
         hw_ff <= SizeW'(320); hh_ff <= SizeW'(240);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIVISIONS:   div_ff  <= csr_data;
            CSR_PETAL_MULT:  mul_ff  <= csr_data;
            CSR_ANGLE_STEP:  step_ff <= csr_data;
            CSR_HALF_WIDTH:  hw_ff   <= csr_data[SizeW-1:0];
            CSR_HALF_HEIGHT: hh_ff   <= csr_data[SizeW-1:0];
            default: ;
         endcase
      end
   end

   // Effective divisions.
   logic [DivW-1:0] d_eff;
   always_comb begin
      d_eff = div_ff;
      if (div_ff == '0) d_eff = DivW'(1);
      if ({1'b0, div_ff} > (DivW+1)'(DMax)) d_eff = DivW'(DMax);
   end

   // Curve state.
   logic [DivW-1:0] ang_ff, left_ff, count_ff, t_ff;
   logic [DivW-1:0] half_d_ff, gcd_ff;

   // Shared restoring divider: one quotient bit per cycle.
   logic [ProdW-1:0]   dv_num_ff;   // dividend shifting out
   logic [DivW:0]      dv_rem_ff;   // partial remainder
   logic [DivW-1:0]    dv_den_ff;
   logic [ProdW-1:0]   dv_quo_ff;
   logic [DivCntW-1:0] dv_cnt_ff;
   logic [DivW:0]      dv_trial;
   logic               dv_ge;

   assign dv_trial = {dv_rem_ff[DivW-1:0], dv_num_ff[ProdW-1]};
   assign dv_ge    = (dv_trial >= {1'b0, dv_den_ff});

   // Polynomial unit.
   logic signed [17:0] u_ff;
   logic signed [17:0] u2_ff;
   logic signed [31:0] acc_ff;
   logic [2:0]         pstep_ff;
   logic               pbusy_ff;
   logic [1:0]         quad_ff;
   logic signed [16:0] sr_ff, ss_ff, sc_ff;
   logic [17:0]        ph_r_ff, ph_b_ff;

   // Multiplier stages.
   logic signed [33:0] prod_ff;
   logic [1:0]         mstep_ff;
   logic signed [46:0] mx_ff, my_ff;
   logic [CoordW-1:0]  x_ff, y_ff;
   logic               last_ff;

   logic               gbusy_ff;
   logic [DivW-1:0]    ga_ff, gb_ff;

   function automatic logic [17:0] scale18(input logic [NumW-1:0] q);
      logic [17:0] r;
      if (PHASE_BITS <= 18) r = 18'(q << (18 - PHASE_BITS));
      else                  r = 18'(q >> (PHASE_BITS - 18));
      return r;
   endfunction

   function automatic logic signed [31:0] poly_c(input logic [2:0] i);
      logic signed [31:0] c;
      unique case (i)
         3'd0: c = POLY_C7;
         3'd1: c = POLY_C5;
         3'd2: c = POLY_C3;
         default: c = POLY_C1;
      endcase
      return c;
   endfunction

   // Polynomial combinational step: one product with a register after it.
   logic signed [49:0] pmul;
   assign pmul = 50'(u2_ff) * 50'(acc_ff);

   logic [17:0] ang_sel;
   always_comb begin
      unique case (cmd.sel)
         2'd0:    ang_sel = ph_r_ff;
         2'd1:    ang_sel = ph_b_ff;
         default: ang_sel = ph_b_ff + 18'h10000;
      endcase
   end

   logic signed [16:0] qs;
   logic signed [47:0] fin;
   assign fin = 48'(u_ff) * 48'(acc_ff);
   always_comb begin
      logic signed [47:0] s;
      s = (fin >>> 16);
      s = (s + 48'sd16384) >>> 15;
      if (s > 48'sd32767) s = 48'sd32767;
      qs = 17'(s);
      if (quad_ff[1]) qs = -qs;
   end

   function automatic logic [CoordW-1:0] floor30(input logic signed [46:0] v,
                                                  input logic [SizeW-1:0] h);
      logic signed [46:0] f;
      f = v >>> 30;
      return CoordW'(f + 47'(h));
   endfunction

   logic busy_any;
   assign busy_any = gbusy_ff || (dv_cnt_ff != '0) || pbusy_ff || (mstep_ff != 2'd0);
   assign sts.busy      = busy_any;
   assign sts.need_init = (left_ff == '0);

   logic [DivW-1:0] d_half;
   assign d_half = ((mul_ff[0] && step_ff[0] && !d_eff[0]) ? (d_eff >> 1) : d_eff);

   // Next angle before reduction; the step may exceed d, so it is divided.
   logic [DivW:0]   t_sum;
   assign t_sum  = {1'b0, t_ff} + {1'b0, step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff <= '0; left_ff <= '0; count_ff <= '0;
         dv_cnt_ff <= '0; pbusy_ff <= 1'b0; mstep_ff <= 2'd0; gbusy_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_START: begin
               ang_ff    <= '0;
               half_d_ff <= d_half;
               // gcd by repeated remainder through the divider
               ga_ff     <= d_half;
               gb_ff     <= step_ff;
            end
            OP_GCD: begin
               if (cmd.first) begin
                  gbusy_ff <= 1'b1;
               end else if (gbusy_ff && dv_cnt_ff == '0) begin
                  if (gb_ff == '0) begin
                     gcd_ff <= ga_ff; gbusy_ff <= 1'b0;
                  end else begin
                     dv_num_ff <= ProdW'(ga_ff) << DivW;
                     dv_den_ff <= gb_ff; dv_rem_ff <= '0;
                     dv_cnt_ff <= DivCntW'(DivW);
                     ga_ff <= gb_ff; gb_ff <= '0;
                     gbusy_ff <= 1'b1;
                  end
               end
               if (dv_cnt_ff == DivCntW'(1)) gb_ff <= dv_ge ? DivW'(dv_trial - {1'b0, dv_den_ff})
                                                              : dv_trial[DivW-1:0];
            end
            OP_CNTDIV: begin
               if (cmd.first) begin
                  dv_num_ff <= ProdW'(half_d_ff) << DivW;
                  dv_den_ff <= gcd_ff; dv_rem_ff <= '0;
                  dv_cnt_ff <= DivCntW'(DivW);
               end else if (dv_cnt_ff == DivCntW'(1)) begin
                  count_ff <= DivW'({dv_quo_ff[DivW-2:0], dv_ge});
                  left_ff  <= DivW'({dv_quo_ff[DivW-2:0], dv_ge});
               end
            end
            OP_PREP: begin
               // Reduce the stored angle by the current d.
               if (cmd.first) begin
                  dv_num_ff <= ProdW'(ang_ff) << DivW;
                  dv_den_ff <= d_eff; dv_rem_ff <= '0;
                  dv_cnt_ff <= DivCntW'(DivW);
               end
            end
            OP_MOD: begin
               // t = angle mod d, then t*a mod d
               if (cmd.first) begin
                  t_ff <= DivW'(dv_rem_ff);
                  dv_num_ff <= ProdW'(DivW'(dv_rem_ff)) * ProdW'(mul_ff);
                  dv_den_ff <= d_eff; dv_rem_ff <= '0;
                  dv_cnt_ff <= DivCntW'(ProdW);
               end
            end
            OP_PHDIV: begin
               // The dividend is below d times 2^PHASE_BITS, so the upper
               // part starts as the partial remainder and only zeros shift in.
               if (cmd.first) begin
                  if (cmd.sel == 2'd0) begin
                     dv_rem_ff <= {1'b0, dv_rem_ff[DivW-1:0]};
                  end else begin
                     ph_r_ff <= scale18(NumW'(dv_quo_ff));
                     dv_rem_ff <= {1'b0, t_ff};
                  end
                  dv_num_ff <= '0;
                  dv_den_ff <= d_eff;
                  dv_cnt_ff <= DivCntW'(PHASE_BITS);
               end else if (cmd.sel == 2'd1 && dv_cnt_ff == DivCntW'(1)) begin
                  ph_b_ff <= scale18(NumW'({dv_quo_ff, dv_ge}));
               end
            end
            OP_SIN: begin
               if (cmd.first) begin
                  quad_ff  <= ang_sel[17:16];
                  u_ff     <= ang_sel[16] ? (18'sh10000 - {2'b0, ang_sel[15:0]})
                                          : {2'b0, ang_sel[15:0]};
                  pstep_ff <= 3'd0;
                  pbusy_ff <= 1'b1;
               end else if (pbusy_ff) begin
                  pstep_ff <= pstep_ff + 3'd1;
                  if (pstep_ff == 3'd0) begin
                     u2_ff  <= 18'(36'(u_ff) * 36'(u_ff) >>> 16);
                     acc_ff <= POLY_C9;
                  end else if (pstep_ff <= 3'd4) begin
                     acc_ff <= poly_c(pstep_ff - 3'd1) - 32'(pmul >>> 16);
                  end else begin
                     pbusy_ff <= 1'b0;
                     unique case (cmd.sel)
                        2'd0:    sr_ff <= qs;
                        2'd1:    ss_ff <= qs;
                        default: sc_ff <= qs;
                     endcase
                  end
               end
            end
            OP_MUL: begin
               if (cmd.first) begin
                  prod_ff  <= 34'(ss_ff) * 34'(sr_ff);
                  mstep_ff <= 2'd1;
                  // Next angle reduced modulo d while the products run.
                  dv_num_ff <= ProdW'(t_sum) << (ProdW - DivW - 1);
                  dv_den_ff <= d_eff; dv_rem_ff <= '0;
                  dv_cnt_ff <= DivCntW'(DivW + 1);
               end else if (mstep_ff == 2'd1) begin
                  mx_ff    <= 47'(prod_ff) * $signed({1'b0, hw_ff});
                  prod_ff  <= 34'(sc_ff) * 34'(sr_ff);
                  mstep_ff <= 2'd2;
               end else if (mstep_ff == 2'd2) begin
                  my_ff    <= 47'(prod_ff) * $signed({1'b0, hh_ff});
                  mstep_ff <= 2'd0;
               end
            end
            OP_FINISH: begin
               x_ff     <= floor30(mx_ff, hw_ff);
               y_ff     <= floor30(my_ff, hh_ff);
               left_ff  <= left_ff - DivW'(1);
               last_ff  <= (left_ff == DivW'(1));
               ang_ff   <= dv_rem_ff[DivW-1:0];
            end
            default: ;
         endcase

         // Divider iteration runs whenever loaded.
         if (dv_cnt_ff != '0) begin
            dv_rem_ff <= dv_ge ? (dv_trial - {1'b0, dv_den_ff}) : dv_trial;
            dv_num_ff <= dv_num_ff << 1;
            dv_quo_ff <= {dv_quo_ff[ProdW-2:0], dv_ge};
            dv_cnt_ff <= dv_cnt_ff - DivCntW'(1);
         end
      end
   end

   assign rsp_x = x_ff;
   assign rsp_y = y_ff;
   assign rsp_vertex_total = count_ff;
   assign rsp_last = last_ff;
endmodule
`default_nettype wire

[rtl/core/rose_curve_vertex_generator.sv]
// ----------------------------------------------------------------------------
// Rose curve vertex generator
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Each request word yields one vertex word. The work per vertex is set by the
// bit-serial divider (the angle reduction, the product reduction, two phase
// divisions and the next-angle reduction) and the six-step sine polynomial
// run three times. Starting a curve adds the gcd, computed by repeated
// remainder steps through the divider, and the count division.
`default_nettype none
`include "assert_macros.svh"
module rose_curve_vertex_generator #(
   parameter int MAX_DIVISIONS = rose_pkg::MaxDivisionsDefault,
   parameter int PHASE_BITS    = rose_pkg::PhaseBitsDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_restart,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [rose_pkg::CoordW-1:0]       rsp_x,
   output logic [rose_pkg::CoordW-1:0]       rsp_y,
   output logic [rose_pkg::DivW-1:0]         rsp_vertex_total,
   output logic                              rsp_last,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [rose_pkg::DivW-1:0]    csr_data
);
   import rose_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   rose_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_restart,
      .rsp_valid, .rsp_ready, .csr_ready, .cmd, .sts
   );

   // Arithmetic.
   rose_dp #(.MAX_DIVISIONS(MAX_DIVISIONS), .PHASE_BITS(PHASE_BITS)) u_dp (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .cmd, .sts, .rsp_x, .rsp_y, .rsp_vertex_total, .rsp_last
   );

   `ASSERT_CLK(a_no_req_while_rsp, clock, reset, rsp_valid |-> !req_ready, "request taken while response pending")
   `ASSERT_CLK(a_rsp_total_nonzero, clock, reset, rsp_valid |-> (rsp_vertex_total != '0), "zero vertex total")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "response after reset")
endmodule
`default_nettype wire
